### hdl/sbcd_pkg.sv
// ----------------------------------------------------------------------------
// sbcd_pkg
// Shared types and constants of the sector buffer cache directory: word
// layouts of both channels, operation and status codes, entry flag bits.
// ----------------------------------------------------------------------------
package sbcd_pkg;

  // default sizes of the directory
  localparam int ENTRIES_DEF     = 32;
  localparam int SECTOR_BITS_DEF = 48;
  localparam int COUNT_BITS_DEF  = 8;

  // fixed field widths of the channel words
  localparam int OP_W     = 3;
  localparam int SECTOR_W = 48;
  localparam int ENTRY_W  = 5;
  localparam int STATUS_W = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_READ_GET      = 3'd0,
    OP_GET_FOR_WRITE = 3'd1,
    OP_RELEASE       = 3'd2,
    OP_MARK_WRITTEN  = 3'd3,
    OP_SYNC          = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_COUNT_ERR = 2'd2
  } status_t;

  // per-entry flag bits
  typedef struct packed {
    logic in_use;
    logic valid;
    logic dirty;
  } ent_flags_t;

  // request word
  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SECTOR_W-1:0] sector;
    logic [ENTRY_W-1:0]  entry;
  } req_word_t;

  // result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_index;
    logic                hit;
    logic                write_back;
    logic [SECTOR_W-1:0] write_back_sector;
    logic                fetch;
    logic                flush;
    logic                last;
  } rsp_word_t;

endpackage

### hdl/sbcd_cell.sv
// ----------------------------------------------------------------------------
// sbcd_cell
// One directory entry: tag, flag bits and reference count. Takes its
// neighbor's entry on shift, or a new entry from the controller on load.
// ----------------------------------------------------------------------------
module sbcd_cell
  import sbcd_pkg::*;
#(
  parameter int TAG_W      = SECTOR_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic                  load,
  input  logic [TAG_W-1:0]      nb_tag,
  input  ent_flags_t            nb_flags,
  input  logic [COUNT_BITS-1:0] nb_count,
  input  logic [TAG_W-1:0]      ld_tag,
  input  ent_flags_t            ld_flags,
  input  logic [COUNT_BITS-1:0] ld_count,
  output logic [TAG_W-1:0]      tag,
  output ent_flags_t            flags,
  output logic [COUNT_BITS-1:0] count
);

  // control part of the entry, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      count <= '0;
    end else if (load) begin
      flags <= ld_flags;
      count <= ld_count;
    end else if (shift) begin
      flags <= nb_flags;
      count <= nb_count;
    end
  end

  // sector tag, only meaningful once the entry is in use
  always_ff @(posedge clk) begin
    if (load) begin
      tag <= ld_tag;
    end else if (shift) begin
      tag <= nb_tag;
    end
  end

endmodule

### hdl/sector_buffer_cache_directory_unit.sv
// ----------------------------------------------------------------------------
// sector_buffer_cache_directory_unit
// Directory of a sector buffer cache held in a ring of entry cells.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one word per operation (read_get, get_for_write, release,
//   mark_written, sync). rsp channel: result words; the final word of an
//   operation has last set. Both channels use valid/stall.
// Operation
//   The entries sit in a ring of ENTRIES cells. Every operation rotates the
//   ring once, one cell per cycle while not paused, and looks only at the
//   head cell: lookups note the lowest match and the lowest free entry,
//   release and mark_written edit their entry as it passes the head, sync
//   emits a word for every dirty entry passing the head. After the turn the
//   ring is home and a lookup writes its chosen cell directly.
// Timing
//   One word is worked on at a time. The last result is loaded once the ring
//   has turned home and the done state finds room on rsp; the next request
//   is taken only after the unit has gone back to idle. A stalled rsp holds
//   its word; during sync the ring pauses while a write-back word cannot be
//   handed on.
// Reset
//   rst clears all flags and counts at once; tags need no reset.
// ----------------------------------------------------------------------------
module sector_buffer_cache_directory_unit
  import sbcd_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int TAG_W = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam int EW    = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  // latched request
  logic [OP_W-1:0]    op_q;
  logic [TAG_W-1:0]   sector_q;
  logic [ENTRY_W-1:0] entry_q;

  // ring position and scan records
  logic [IDX_W-1:0]      pos;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  ent_flags_t            hit_flags;
  logic [COUNT_BITS-1:0] hit_count;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_wb;
  logic [TAG_W-1:0]      free_tag;
  logic                  rel_ok;

  // cell row
  logic [TAG_W-1:0]      cell_tag   [ENTRIES];
  ent_flags_t            cell_flags [ENTRIES];
  logic [COUNT_BITS-1:0] cell_count [ENTRIES];

  logic [TAG_W-1:0]      fb_tag;
  ent_flags_t            fb_flags;
  logic [COUNT_BITS-1:0] fb_count;

  logic                  step;
  logic                  commit;
  logic [IDX_W-1:0]      commit_idx;
  ent_flags_t            commit_flags;
  logic [COUNT_BITS-1:0] commit_count;

  logic      is_lookup, for_read, is_sync, is_release, is_mark;
  logic      head_match, head_free, head_dirty, pos_is_entry;
  logic      sync_emit, out_free, done_fire, rsp_load;
  rsp_word_t done_word, sync_word, rsp_next;

  function automatic logic [ENTRY_W-1:0] to_index(input logic [IDX_W-1:0] p);
    logic [EW-1:0] w;
    w = EW'(p);
    return w[ENTRY_W-1:0];
  endfunction

  // operation decode
  assign for_read   = (op_q == OP_READ_GET);
  assign is_lookup  = (op_q == OP_READ_GET) || (op_q == OP_GET_FOR_WRITE);
  assign is_release = (op_q == OP_RELEASE);
  assign is_mark    = (op_q == OP_MARK_WRITTEN);
  assign is_sync    = (op_q == OP_SYNC);

  // head cell view
  assign head_match = cell_flags[0].in_use && (cell_tag[0] == sector_q) &&
                      (!for_read || cell_flags[0].valid);
  assign head_free    = (cell_count[0] == '0);
  assign head_dirty   = cell_flags[0].in_use && cell_flags[0].dirty;
  assign pos_is_entry = (EW'(pos) == EW'(entry_q));

  // ring advance, paused while a sync word waits for room
  assign out_free  = !rsp_valid || !rsp_stall;
  assign sync_emit = (state == S_SCAN) && is_sync && head_dirty;
  assign step      = (state == S_SCAN) && (!sync_emit || out_free);
  assign done_fire = (state == S_DONE) && out_free;

  // head entry as handed back to the tail
  always_comb begin
    fb_tag   = cell_tag[0];
    fb_flags = cell_flags[0];
    fb_count = cell_count[0];
    if (is_sync && head_dirty) begin
      fb_flags.dirty = 1'b0;
    end
    if (is_mark && pos_is_entry) begin
      fb_flags.dirty = 1'b0;
    end
    if (is_release && pos_is_entry && !head_free) begin
      fb_count = cell_count[0] - COUNT_BITS'(1);
    end
  end

  // lookup write into the chosen cell once the ring is home
  assign commit = done_fire && is_lookup &&
                  (hit_found ? !(&hit_count) : free_found);
  assign commit_idx = hit_found ? hit_idx : free_idx;

  always_comb begin
    if (hit_found) begin
      commit_flags = hit_flags;
      commit_count = hit_count + COUNT_BITS'(1);
    end else begin
      commit_flags.in_use = 1'b1;
      commit_flags.valid  = for_read;
      commit_flags.dirty  = !for_read;
      commit_count        = COUNT_BITS'(1);
    end
  end

  // ring of entry cells
  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic                  ld;
      logic [TAG_W-1:0]      nb_tag;
      ent_flags_t            nb_flags;
      logic [COUNT_BITS-1:0] nb_count;

      assign ld = commit && (commit_idx == IDX_W'(gi));

      if (gi == ENTRIES - 1) begin : g_tail
        assign nb_tag   = fb_tag;
        assign nb_flags = fb_flags;
        assign nb_count = fb_count;
      end else begin : g_link
        assign nb_tag   = cell_tag[gi+1];
        assign nb_flags = cell_flags[gi+1];
        assign nb_count = cell_count[gi+1];
      end

      sbcd_cell #(
        .TAG_W      (TAG_W),
        .COUNT_BITS (COUNT_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (step),
        .load     (ld),
        .nb_tag   (nb_tag),
        .nb_flags (nb_flags),
        .nb_count (nb_count),
        .ld_tag   (sector_q),
        .ld_flags (commit_flags),
        .ld_count (commit_count),
        .tag      (cell_tag[gi]),
        .flags    (cell_flags[gi]),
        .count    (cell_count[gi])
      );
    end
  endgenerate

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step && (pos == LAST_POS)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request latch and scan records
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_valid) begin
      op_q       <= req.operation;
      sector_q   <= req.sector[TAG_W-1:0];
      entry_q    <= req.entry;
      pos        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      rel_ok     <= 1'b0;
    end else if (step) begin
      pos <= pos + IDX_W'(1);
      if (is_lookup && head_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= pos;
        hit_flags <= cell_flags[0];
        hit_count <= cell_count[0];
      end
      if (is_lookup && head_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pos;
        free_wb    <= head_dirty;
        free_tag   <= cell_tag[0];
      end
      if (is_release && pos_is_entry) begin
        rel_ok <= !head_free;
      end
    end
  end

  // final result word
  always_comb begin
    done_word      = '0;
    done_word.last = 1'b1;
    case (op_q)
      OP_READ_GET, OP_GET_FOR_WRITE: begin
        if (hit_found) begin
          done_word.hit         = 1'b1;
          done_word.entry_index = to_index(hit_idx);
          done_word.status      = (&hit_count) ? ST_COUNT_ERR : ST_OK;
        end else if (free_found) begin
          done_word.entry_index = to_index(free_idx);
          done_word.write_back  = free_wb;
          done_word.write_back_sector = free_wb ? SECTOR_W'(free_tag) : '0;
          done_word.fetch       = for_read;
        end else begin
          done_word.status = ST_NO_FREE;
        end
      end
      OP_RELEASE: begin
        done_word.status      = rel_ok ? ST_OK : ST_COUNT_ERR;
        done_word.entry_index = entry_q;
      end
      OP_MARK_WRITTEN: begin
        done_word.entry_index = entry_q;
      end
      OP_SYNC: begin
        done_word.flush = 1'b1;
      end
      default: ;
    endcase
  end

  // sync write-back word for the head entry
  always_comb begin
    sync_word                   = '0;
    sync_word.entry_index       = to_index(pos);
    sync_word.write_back        = 1'b1;
    sync_word.write_back_sector = SECTOR_W'(cell_tag[0]);
  end

  assign rsp_load = (sync_emit && step) || done_fire;
  assign rsp_next = (state == S_DONE) ? done_word : sync_word;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  assign req_stall = (state != S_IDLE);

endmodule

### hdl/sbcd_checker.sv
// ----------------------------------------------------------------------------
// sbcd_checker
// Port-level checks of the directory unit, bound to the top level.
// ----------------------------------------------------------------------------
module sbcd_checker
  import sbcd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input req_word_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_word_t rsp
);

  // a stalled request word holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("req word changed while stalled");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp word changed while stalled");

  // one operation at a time: an accepted word closes the request side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in work");

  // the flush word ends its operation
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.flush |-> rsp.last)
    else $error("flush word without last");

  // no write-back sector without write-back
  a_wb_sector: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.write_back |-> (rsp.write_back_sector == '0))
    else $error("write-back sector set without write-back");

endmodule

bind sector_buffer_cache_directory_unit sbcd_checker u_sbcd_checker (.*);
